// File: src/rsg_pkg.sv
// Shared types and constants for the star and grid line generator.
`default_nettype none

package rsg_pkg;

	typedef enum logic [1:0] {
		OP_LOAD       = 2'd0,
		OP_LINE_START = 2'd1,
		OP_PIXEL      = 2'd2,
		OP_LINE_END   = 2'd3
	} op_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_LINE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LAST_LINE     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FLIPPED       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLOR    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_PPL           = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_VISIBLE_WIDTH = 3'd6;

	localparam logic [10:0] HALF_OFFSET   = 11'h400;
	localparam int          STAR_BIT      = 7;
	localparam logic [9:0]  BACK_PEN_BASE = 10'd256;
	localparam logic [9:0]  GRID_PEN_BASE = 10'd512;
	localparam logic [9:0]  STAR_PEN      = 10'd520;

	typedef struct packed {
		logic [8:0]  first_line;
		logic [8:0]  last_line;
		logic        flipped;
		logic [2:0]  grid_color;
		logic [9:0]  ppl;
		logic [15:0] half_period;
		logic [8:0]  visible_width;
	} cfg_t;

	// classified item as handed from front to back
	typedef struct packed {
		op_t         op;
		logic [10:0] addr;
		logic        load_ok;
		logic [7:0]  data;
		logic [8:0]  px;
		logic [7:0]  blue;
		logic        grid;
		logic        clear_idx;
		logic        upper;
	} cmd_t;

endpackage

`default_nettype wire

// File: src/rsg_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none

module rsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/rsg_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none

module rsg_front
	import rsg_pkg::*;
#(
	parameter int TABLE_DEPTH = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  operation,
	input  wire logic [10:0] table_address,
	input  wire logic [7:0]  table_byte,
	input  wire logic [8:0]  line_number,
	input  wire logic [8:0]  pixel_x,
	input  wire logic [7:0]  blue_value,
	input  wire logic        grid_signal,
	input  wire logic        noise_flip,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  wire logic        cmd_take
);

	localparam int XW = ($clog2(TABLE_DEPTH + 1) > 11) ? $clog2(TABLE_DEPTH + 1) : 11;

	cmd_t       q_mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       acc;

	always_comb begin
		cls.op        = op_t'(operation);
		cls.addr      = table_address;
		cls.load_ok   = XW'(table_address) < XW'(TABLE_DEPTH);
		cls.data      = table_byte;
		cls.px        = pixel_x;
		cls.blue      = blue_value;
		cls.grid      = grid_signal;
		cls.clear_idx = (line_number <= cfg.first_line) || (line_number > cfg.last_line);
		cls.upper     = ~(cfg.flipped ^ noise_flip);
	end

	assign full      = (cnt_q == 2'd2);
	assign acc       = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			q_mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				wr_q <= ~wr_q;
			end
			if (cmd_take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(acc) - 2'(cmd_take);
		end
	end

endmodule

`default_nettype wire

// File: src/rsg_back.sv
// Back end: walks the dot table, keeps the blink state and queues pens.
`default_nettype none

module rsg_back
	import rsg_pkg::*;
#(
	parameter int TABLE_DEPTH = 2048
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       cmd_valid,
	input  wire cmd_t       cmd,
	output logic            cmd_take,
	output logic            empty,
	input  wire logic       pop,
	output logic      [9:0] pen_index
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IW = $clog2(TABLE_DEPTH + 1);
	localparam int XW = (IW > 11) ? IW : 11;

	typedef enum logic [3:0] {
		B_IDLE  = 4'b0001,
		B_EVAL  = 4'b0010,
		B_FETCH = 4'b0100,
		B_SKIP  = 4'b1000
	} bstate_t;

	bstate_t     state_q;
	logic [IW-1:0] idx_q;
	logic        flag_q;
	logic [16:0] acc_q;
	logic [7:0]  blue_q;
	logic        grid_q;
	logic        upper_q;
	logic        ok_q;
	logic [8:0]  px_q;

	logic [9:0]  oq_mem_q [2];
	logic        oq_wr_q;
	logic        oq_rd_q;
	logic [1:0]  oq_cnt_q;
	logic        oq_full;
	logic        oq_push;
	logic        oq_pop;

	logic [XW-1:0] idx_x;
	logic [XW-1:0] addr_x;
	logic        fetch_ok;
	logic [7:0]  rd_data;
	logic [8:0]  dot_pos;
	logic        hit;
	logic        skip;
	logic [9:0]  pen;
	logic        ram_we;
	logic [16:0] acc_sum;
	logic        toggle;
	logic [16:0] acc_next;

	always_comb begin
		idx_x    = XW'(idx_q);
		addr_x   = idx_x | (upper_q ? XW'(HALF_OFFSET) : '0);
		fetch_ok = (idx_x < XW'(TABLE_DEPTH)) && (addr_x < XW'(TABLE_DEPTH));
		dot_pos  = {rd_data[6:0], 2'b00};
		hit      = ok_q && (px_q == dot_pos);
		skip     = ok_q && (cfg.visible_width < dot_pos);
		pen      = BACK_PEN_BASE + {2'b00, blue_q};
		if (hit) begin
			if (flag_q && rd_data[STAR_BIT]) begin
				pen = STAR_PEN;
			end else if (grid_q && !rd_data[STAR_BIT]) begin
				pen = GRID_PEN_BASE + {7'd0, cfg.grid_color};
			end
		end
		acc_sum  = acc_q + 17'(cfg.ppl);
		toggle   = acc_sum > 17'(cfg.half_period);
		acc_next = toggle ? (acc_sum - 17'(cfg.half_period)) : acc_sum;
	end

	assign oq_full  = (oq_cnt_q == 2'd2);
	assign cmd_take = (state_q == B_IDLE) && cmd_valid && ((cmd.op != OP_PIXEL) || !oq_full);
	assign ram_we   = cmd_take && (cmd.op == OP_LOAD) && cmd.load_ok;
	assign oq_push  = (state_q == B_EVAL);
	assign empty    = (oq_cnt_q == 2'd0);
	assign oq_pop   = pop && !empty;
	assign pen_index = oq_mem_q[oq_rd_q];

	rsg_ram #(
		.WIDTH (8),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cmd.addr)),
		.wdata (cmd.data),
		.raddr (addr_x[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
			flag_q  <= 1'b0;
			acc_q   <= '0;
			blue_q  <= '0;
			grid_q  <= 1'b0;
			upper_q <= 1'b0;
			ok_q    <= 1'b0;
			px_q    <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (cmd_take) begin
						unique case (cmd.op)
							OP_LINE_START: begin
								blue_q  <= cmd.blue;
								grid_q  <= cmd.grid;
								upper_q <= cmd.upper;
								acc_q   <= acc_next;
								if (toggle) begin
									flag_q <= ~flag_q;
								end
								if (cmd.clear_idx) begin
									idx_q <= '0;
								end
							end
							OP_PIXEL: begin
								px_q    <= cmd.px;
								ok_q    <= fetch_ok;
								state_q <= B_EVAL;
							end
							OP_LINE_END: begin
								ok_q    <= fetch_ok;
								state_q <= B_SKIP;
							end
							OP_LOAD: begin
							end
						endcase
					end
				end
				B_EVAL: begin
					// consume the entry on a match
					if (hit) begin
						idx_q <= idx_q + IW'(1);
					end
					state_q <= B_IDLE;
				end
				B_SKIP: begin
					if (skip) begin
						idx_q   <= idx_q + IW'(1);
						state_q <= B_FETCH;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_FETCH: begin
					// table is read at the advanced index this cycle
					ok_q    <= fetch_ok;
					state_q <= B_SKIP;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem_q[oq_wr_q] <= pen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= ~oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= ~oq_rd_q;
			end
			oq_cnt_q <= oq_cnt_q + 2'(oq_push) - 2'(oq_pop);
		end
	end

endmodule

`default_nettype wire

// File: src/radar_star_grid_line_generator.sv
// Top level of the star and grid background line generator.
//
//   channel   direction  handshake            payload
//   input     in         push / full          operation .. noise_flip
//   result    out        empty / pop          pen_index
//   config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// Load and line-start items finish in the back end's idle state; a pixel item
// reads the table, then compares; a line end does the same, then advances and
// reads again per skipped entry. The registered table read port splits reads and
// compares; a two-deep item queue and a two-deep result queue let input and output stall independently.
// Reset clears all control state; table contents are undefined until loaded.
`default_nettype none

module radar_star_grid_line_generator
	import rsg_pkg::*;
#(
	parameter int TABLE_DEPTH = 2048
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [1:0]             operation,
	input  wire logic [10:0]            table_address,
	input  wire logic [7:0]             table_byte,
	input  wire logic [8:0]             line_number,
	input  wire logic [8:0]             pixel_x,
	input  wire logic [7:0]             blue_value,
	input  wire logic                   grid_signal,
	input  wire logic                   noise_flip,
	output logic                        empty,
	input  wire logic                   pop,
	output logic      [9:0]             pen_index,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_line    <= 9'd16;
			cfg_q.last_line     <= 9'd239;
			cfg_q.flipped       <= 1'b0;
			cfg_q.grid_color    <= 3'd0;
			cfg_q.ppl           <= 10'd384;
			cfg_q.half_period   <= 16'd459;
			cfg_q.visible_width <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRST_LINE:    cfg_q.first_line    <= cfg_data[8:0];
				CFG_LAST_LINE:     cfg_q.last_line     <= cfg_data[8:0];
				CFG_FLIPPED:       cfg_q.flipped       <= cfg_data[0];
				CFG_GRID_COLOR:    cfg_q.grid_color    <= cfg_data[2:0];
				CFG_PPL:           cfg_q.ppl           <= cfg_data[9:0];
				CFG_HALF_PERIOD:   cfg_q.half_period   <= cfg_data[15:0];
				CFG_VISIBLE_WIDTH: cfg_q.visible_width <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	rsg_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.table_address (table_address),
		.table_byte    (table_byte),
		.line_number   (line_number),
		.pixel_x       (pixel_x),
		.blue_value    (blue_value),
		.grid_signal   (grid_signal),
		.noise_flip    (noise_flip),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_take      (cmd_take)
	);

	rsg_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.pen_index (pen_index)
	);

endmodule

`default_nettype wire

// File: src/rsg_checker.sv
// Port-level checker for the line generator, bound to the top level.
`default_nettype none

module rsg_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       full,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [9:0] pen_index
);

	// both queues come out of reset empty
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("queues not empty after reset");

	// a waiting item holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pen_index))
		else $error("waiting item changed before pop");

	// only background, grid or star pens are produced
	a_pen_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pen_index[9:8] == 2'b01) ||
			(pen_index[9:3] == 7'b1000000) || (pen_index == 10'd520))
		else $error("illegal pen code");

endmodule

bind radar_star_grid_line_generator rsg_checker u_rsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.pen_index (pen_index)
);

`default_nettype wire

// File: tb/tb_radar_star_grid_line_generator.sv
// Testbench for the star and grid line generator: predicted pens checked against the block.
module tb_radar_star_grid_line_generator import rsg_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DOT_DEPTH = 2048;

	typedef struct {
		op_t        op;
		logic [10:0] addr;
		logic [7:0] tbyte;
		logic [8:0] line;
		logic [8:0] px;
		logic [7:0] blue;
		logic       grid;
		logic       nflip;
	} item_t;

	// Tracks the generator's state and the pens still owed by the block.
	class pen_scoreboard;
		logic [7:0]  dots [DOT_DEPTH];
		bit          loaded [DOT_DEPTH];
		int          walk;
		bit          blink;
		logic [16:0] blink_acc;
		logic [7:0]  blue;
		bit          grid_on;
		bit          upper;
		cfg_t        regs;
		logic [9:0]  pens_due [$];
		int          mismatches;

		function new();
			regs.first_line    = 9'd16;
			regs.last_line     = 9'd239;
			regs.flipped       = 1'b0;
			regs.grid_color    = 3'd0;
			regs.ppl           = 10'd384;
			regs.half_period   = 16'd459;
			regs.visible_width = 9'd256;
			walk       = 0;
			blink      = 1'b0;
			blink_acc  = '0;
			blue       = '0;
			grid_on    = 1'b0;
			upper      = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_FIRST_LINE:    regs.first_line    = v[8:0];
				CFG_LAST_LINE:     regs.last_line     = v[8:0];
				CFG_FLIPPED:       regs.flipped       = v[0];
				CFG_GRID_COLOR:    regs.grid_color    = v[2:0];
				CFG_PPL:           regs.ppl           = v[9:0];
				CFG_HALF_PERIOD:   regs.half_period   = v[15:0];
				CFG_VISIBLE_WIDTH: regs.visible_width = v[8:0];
				default: ;
			endcase
		endfunction

		// Table address for a walk position; -1 where nothing can be read.
		function int address_of(int w);
			int a;
			if (w >= DOT_DEPTH)
				return -1;
			a = w | (upper ? int'(HALF_OFFSET) : 0);
			if (a >= DOT_DEPTH)
				return -1;
			return a;
		endfunction

		function bit current_entry(output logic [7:0] e);
			int a;
			a = address_of(walk);
			if (a < 0)
				return 1'b0;
			e = dots[a];
			return 1'b1;
		endfunction

		// First entry the item would read before it has ever been loaded, or -1.
		function int unread_address(op_t op);
			int w;
			int a;
			if (op != OP_PIXEL && op != OP_LINE_END)
				return -1;
			w = walk;
			while (1) begin
				a = address_of(w);
				if (a < 0)
					return -1;
				if (!loaded[a])
					return a;
				if (op == OP_PIXEL || int'(regs.visible_width) >= 4 * int'(dots[a][6:0]))
					return -1;
				w++;
			end
		endfunction

		function void note_item(item_t it);
			logic [7:0] e;
			logic [9:0] pen;
			case (it.op)
				OP_LOAD: begin
					dots[it.addr]   = it.tbyte;
					loaded[it.addr] = 1'b1;
				end
				OP_LINE_START: begin
					blue      = it.blue;
					grid_on   = it.grid;
					blink_acc = blink_acc + 17'(regs.ppl);
					if (blink_acc > 17'(regs.half_period)) begin
						blink     = !blink;
						blink_acc = blink_acc - 17'(regs.half_period);
					end
					if (it.line <= regs.first_line || it.line > regs.last_line)
						walk = 0;
					upper = !(regs.flipped ^ it.nflip);
				end
				OP_PIXEL: begin
					pen = BACK_PEN_BASE + 10'(blue);
					if (current_entry(e) && int'(it.px) == 4 * int'(e[6:0])) begin
						if (blink && e[STAR_BIT])
							pen = STAR_PEN;
						else if (grid_on && !e[STAR_BIT])
							pen = GRID_PEN_BASE + 10'(regs.grid_color);
						walk++;
					end
					pens_due.push_back(pen);
				end
				default: begin
					// skip entries that lie beyond the visible width
					while (current_entry(e) && int'(regs.visible_width) < 4 * int'(e[6:0]))
						walk++;
				end
			endcase
		endfunction

		function void check_pen(logic [9:0] got);
			logic [9:0] want;
			if (pens_due.size() == 0) begin
				$error("pen_index: got %0d with no pen expected", got);
				mismatches++;
				return;
			end
			want = pens_due.pop_front();
			if (got !== want) begin
				$error("pen_index: expected %0d, got %0d", want, got);
				mismatches++;
			end
		endfunction

		function int pending();
			return pens_due.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push;
	logic                   full;
	logic [1:0]             operation;
	logic [10:0]            table_address;
	logic [7:0]             table_byte;
	logic [8:0]             line_number;
	logic [8:0]             pixel_x;
	logic [7:0]             blue_value;
	logic                   grid_signal;
	logic                   noise_flip;
	logic                   empty;
	logic                   pop;
	logic [9:0]             pen_index;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	pen_scoreboard pens;
	int            items_sent = 0;
	bit            steady = 1'b0;
	int            hold_pops = 0;

	radar_star_grid_line_generator #(.TABLE_DEPTH(DOT_DEPTH)) uut (.*);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic item_t random_item(op_t op);
		item_t it;
		it.op    = op;
		it.addr  = 11'($urandom);
		it.tbyte = 8'($urandom);
		it.line  = 9'($urandom);
		it.px    = 9'($urandom);
		it.blue  = 8'($urandom);
		it.grid  = 1'($urandom);
		it.nflip = 1'($urandom);
		return it;
	endfunction

	function automatic item_t make_item(op_t op, int addr, int tbyte, int line, int px,
			int blue, int grid, int nflip);
		item_t it;
		it.op    = op;
		it.addr  = 11'(addr);
		it.tbyte = 8'(tbyte);
		it.line  = 9'(line);
		it.px    = 9'(px);
		it.blue  = 8'(blue);
		it.grid  = 1'(grid);
		it.nflip = 1'(nflip);
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation     <= it.op;
		table_address <= it.addr;
		table_byte    <= it.tbyte;
		line_number   <= it.line;
		pixel_x       <= it.px;
		blue_value    <= it.blue;
		grid_signal   <= it.grid;
		noise_flip    <= it.nflip;
		push          <= 1'b1;
		do @(posedge clk); while (full);
		items_sent++;
		pens.note_item(it);
	endtask

	// Load every entry the next item would read before it is sent.
	task automatic make_readable(input op_t op);
		item_t ld;
		int    a;
		a = pens.unread_address(op);
		while (a >= 0) begin
			ld = random_item(OP_LOAD);
			ld.addr = 11'(a);
			// end some skips early so line ends stay short
			if (op == OP_LINE_END && $urandom_range(0, 1) == 1)
				ld.tbyte[6:0] = 7'($urandom_range(0, int'(pens.regs.visible_width) / 4));
			send_item(ld);
			a = pens.unread_address(op);
		end
	endtask

	task automatic send_checked(input item_t it);
		make_readable(it.op);
		send_item(it);
	endtask

	task automatic send_pixel(input bit aim);
		item_t      it;
		logic [7:0] e;
		make_readable(OP_PIXEL);
		it = random_item(OP_PIXEL);
		if (aim && pens.current_entry(e))
			it.px = {e[6:0], 2'b00};
		send_item(it);
	endtask

	task automatic run_line();
		item_t it;
		it = random_item(OP_LINE_START);
		if ($urandom_range(0, 9) < 7 && pens.regs.first_line < pens.regs.last_line)
			it.line = 9'($urandom_range(int'(pens.regs.first_line) + 1,
				int'(pens.regs.last_line)));
		it.grid = ($urandom_range(0, 3) != 0);
		send_item(it);
		repeat ($urandom_range(4, 24)) send_pixel(1'($urandom_range(0, 1)));
		send_checked(random_item(OP_LINE_END));
	endtask

	task automatic run_random(input int count);
		int stop;
		stop = items_sent + count;
		while (items_sent < stop) begin
			steady = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) < 7)
				run_line();
			else
				repeat ($urandom_range(1, 6))
					send_checked(random_item(op_t'($urandom_range(0, 3))));
		end
		steady = 1'b0;
	endtask

	// The pixel's pen only comes out once everything before it has finished.
	task automatic drain();
		send_pixel(1'b0);
		@(negedge clk);
		push <= 1'b0;
		while (pens.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(v);
		pens.set_reg(idx, CFG_DATA_W'(v));
	endtask

	task automatic set_config(input int first, input int last, input int flip,
			input int color, input int ppl, input int half, input int width);
		write_reg(CFG_FIRST_LINE, first);
		write_reg(CFG_LAST_LINE, last);
		write_reg(CFG_FLIPPED, flip);
		write_reg(CFG_GRID_COLOR, color);
		write_reg(CFG_PPL, ppl);
		write_reg(CFG_HALF_PERIOD, half);
		write_reg(CFG_VISIBLE_WIDTH, width);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int stall;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = pick_gap();
			if (hold_pops > 0) begin
				stall = hold_pops;
				hold_pops = 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			if (!empty)
				pens.check_pen(pen_index);
		end
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		item_t it;
		pens          = new();
		push          = 1'b0;
		operation     = '0;
		table_address = '0;
		table_byte    = '0;
		line_number   = '0;
		pixel_x       = '0;
		blue_value    = '0;
		grid_signal   = 1'b0;
		noise_flip    = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_config(16, 239, 0, 0, 384, 459, 256);
		send_checked(make_item(OP_LOAD, 'h400, 'h82, 0, 0, 0, 0, 0));
		send_checked(make_item(OP_LOAD, 'h401, 'h03, 0, 0, 0, 0, 0));
		send_checked(make_item(OP_LOAD, 'h402, 'h7f, 0, 0, 0, 0, 0));
		send_checked(make_item(OP_LOAD, 'h403, 'h00, 0, 0, 0, 0, 0));
		send_checked(make_item(OP_LOAD, 'h7ff, 'hff, 0, 0, 0, 0, 0));
		send_checked(make_item(OP_LOAD, 'h000, 'h00, 0, 0, 0, 0, 0));
		// line 0 lies before the visible area: walk restarts in the upper half
		send_checked(make_item(OP_LINE_START, 0, 0, 0, 0, 'hff, 1, 0));
		send_checked(make_item(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0));
		send_checked(make_item(OP_PIXEL, 0, 0, 0, 8, 0, 0, 0));
		send_checked(make_item(OP_PIXEL, 0, 0, 0, 12, 0, 0, 0));
		send_checked(make_item(OP_LINE_END, 0, 0, 0, 0, 0, 0, 0));
		send_checked(make_item(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0));
		send_checked(make_item(OP_LINE_START, 0, 0, 511, 0, 0, 0, 1));
		send_checked(make_item(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0));
		send_checked(make_item(OP_PIXEL, 0, 0, 0, 511, 0, 0, 0));
		send_checked(make_item(OP_LINE_START, 0, 0, 16, 0, 0, 1, 1));
		send_checked(make_item(OP_LINE_START, 0, 0, 17, 0, 0, 1, 0));
		send_checked(make_item(OP_LINE_START, 0, 0, 239, 0, 0, 1, 0));
		send_checked(make_item(OP_LINE_START, 0, 0, 240, 0, 0, 1, 0));
		send_checked(make_item(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0));
		send_checked(make_item(OP_LINE_END, 0, 0, 0, 0, 0, 0, 0));

		run_random(30);
		// hold the receiver back while pixels keep coming, so the block fills up
		hold_pops = 80;
		steady = 1'b1;
		repeat (40) send_pixel(1'b1);
		steady = 1'b0;
		run_random(40);

		drain();
		set_config(0, 511, 1, 7, 1023, 1, 511);
		run_random(40);

		drain();
		set_config(511, 0, 0, 5, 1, 65535, 1);
		run_random(30);

		drain();
		set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		run_random(40);

		// zero half period: blink toggles every line and the accumulator wraps
		drain();
		set_config(16, 239, 0, 0, 1023, 0, 256);
		repeat (140) send_checked(random_item(OP_LINE_START));

		// fill the upper half so one line end walks the index to the table depth
		drain();
		set_config(0, 511, 0, 3, 384, 459, 1);
		steady = 1'b1;
		for (int a = int'(HALF_OFFSET); a < DOT_DEPTH; a++) begin
			it = random_item(OP_LOAD);
			it.addr = 11'(a);
			it.tbyte[6:0] = 7'($urandom_range(1, 127));
			send_item(it);
		end
		steady = 1'b0;
		it = random_item(OP_LINE_START);
		it.nflip = 1'b0;
		send_checked(it);
		send_checked(random_item(OP_LINE_END));
		repeat (8) send_pixel(1'b1);
		send_checked(random_item(OP_LINE_END));

		drain();
		repeat (20) @(posedge clk);
		if (pens.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
